// File: design/pbh_pkg.sv
// shared types, command codes and defaults for the packet byte histogram
`default_nettype none

package pbh_pkg;

  localparam int NumBins         = 256;
  localparam int BinW            = 8;
  localparam int FieldSizeW      = 16;
  localparam int OutW            = 32;
  localparam int CountWidthDflt  = 32;
  localparam int SizeWidthDflt   = 16;

  localparam logic [1:0] CmdCount = 2'd0;
  localparam logic [1:0] CmdRead  = 2'd1;
  localparam logic [1:0] CmdClear = 2'd2;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [BinW-1:0]       byte_value;
    logic [FieldSizeW-1:0] packet_size;
    logic                  last_in_packet;
    logic [BinW-1:0]       bin_index;
  } in_t;

  typedef struct packed {
    logic [OutW-1:0] bin_count;
    logic [OutW-1:0] total_bytes;
    logic [OutW-1:0] total_packets;
  } out_t;

endpackage

`default_nettype wire

// File: design/packet_byte_histogram_core.sv
// top level of the packet byte histogram: 256 bins, byte total, packet total
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------
//   in      | input     | in_valid / in_stall | pbh_pkg::in_t (cmd, byte, size)
//   out     | output    | out_valid/out_stall | pbh_pkg::out_t (bin, totals)
//   cfg     | input     | cfg_wr_en           | max_packet_size
//
// one item per cycle while in_stall is low; each item waits in the lookup stage
// while the bin memory read completes, then is applied as it leaves that stage
// a count or read right behind a count of the same bin, or behind a clear, picks
// up the pending value from the forwarding register instead of the stale memory word
// clear: per-bin valid bits drop at once, no memory sweep
// reset (rst_n low, synchronous) empties the pipeline, drops all valid bits,
// zeroes both totals and max_packet_size (counting off)
// in_stall rises only while a read sits in the lookup stage behind a result
// that out_stall holds in the output register
`default_nettype none

module packet_byte_histogram_core #(
  parameter int COUNT_WIDTH = pbh_pkg::CountWidthDflt,
  parameter int SIZE_WIDTH  = pbh_pkg::SizeWidthDflt
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire pbh_pkg::in_t                   in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output pbh_pkg::out_t                       out_data,
  input  wire logic                           cfg_wr_en,
  input  wire logic [pbh_pkg::FieldSizeW-1:0] cfg_wr_data
);

  // packet sizes are compared on the narrower of the field and SIZE_WIDTH
  localparam int SzW = (SIZE_WIDTH < pbh_pkg::FieldSizeW) ? SIZE_WIDTH
                                                           : pbh_pkg::FieldSizeW;
  localparam int BinW = pbh_pkg::BinW;

  // configuration
  logic [SzW-1:0] max_size_r;

  // lookup stage
  logic             s1_vld_r;
  logic [1:0]       s1_cmd_r;
  logic [BinW-1:0]  s1_addr_r;
  logic [SzW-1:0]   s1_size_r;
  logic             s1_last_r;
  logic             rd_vld_r;
  logic             fwd_r;
  logic [COUNT_WIDTH-1:0] fwd_data_r;

  // state
  logic [pbh_pkg::NumBins-1:0] vld_r;
  logic [COUNT_WIDTH-1:0]      byte_tot_r;
  logic [COUNT_WIDTH-1:0]      pkt_tot_r;

  // output register
  logic          out_valid_r;
  pbh_pkg::out_t out_data_r;

  logic                   accept;
  logic                   s1_go;
  logic                   cnt_en;
  logic                   is_clear;
  logic                   is_read;
  logic                   wr_en;
  logic                   hit;
  logic [BinW-1:0]        in_addr;
  logic [COUNT_WIDTH-1:0] ram_rd;
  logic [COUNT_WIDTH-1:0] old_cnt;
  logic [COUNT_WIDTH-1:0] new_cnt;

  // address depends on the command: bin to read or byte to count
  assign in_addr = (in_data.cmd == pbh_pkg::CmdRead) ? in_data.bin_index
                                                     : in_data.byte_value;

  assign is_read  = (s1_cmd_r == pbh_pkg::CmdRead);
  assign is_clear = (s1_cmd_r == pbh_pkg::CmdClear);

  // byte counts only with monitoring on and packet within the limit
  assign cnt_en = (s1_cmd_r == pbh_pkg::CmdCount) && (max_size_r != '0) &&
                  (s1_size_r <= max_size_r);

  // a read can only leave when the output register is free or draining
  assign s1_go    = s1_vld_r && (!is_read || !out_valid_r || !out_stall);
  assign in_stall = s1_vld_r && !s1_go;
  assign accept   = in_valid && !in_stall;
  assign wr_en    = s1_go && cnt_en;

  // effective bin value: forwarded, stored, or zero if never written
  always_comb begin
    if (fwd_r) begin
      old_cnt = fwd_data_r;
    end else if (rd_vld_r) begin
      old_cnt = ram_rd;
    end else begin
      old_cnt = '0;
    end
  end

  assign new_cnt = old_cnt + COUNT_WIDTH'(1);

  // the incoming transfer reads the memory on the same edge the lookup
  // stage writes, so same-bin or clear overlaps go through the forward path
  assign hit = s1_go && ((wr_en && (in_addr == s1_addr_r)) || is_clear);

  pbh_bin_ram #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_bin_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (in_addr),
    .rd_data (ram_rd),
    .wr_en   (wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (new_cnt)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_size_r <= '0;
    end else if (cfg_wr_en) begin
      max_size_r <= cfg_wr_data[SzW-1:0];
    end
  end

  // lookup stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      fwd_r    <= 1'b0;
      rd_vld_r <= 1'b0;
    end else if (accept) begin
      s1_vld_r <= 1'b1;
      fwd_r    <= hit;
      rd_vld_r <= vld_r[in_addr];
    end else if (s1_go) begin
      s1_vld_r <= 1'b0;
    end
  end

  // lookup stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd_r   <= in_data.cmd;
      s1_addr_r  <= in_addr;
      s1_size_r  <= in_data.packet_size[SzW-1:0];
      s1_last_r  <= in_data.last_in_packet;
      fwd_data_r <= is_clear ? '0 : new_cnt;
    end
  end

  // per-bin valid bits and totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      byte_tot_r <= '0;
      pkt_tot_r  <= '0;
    end else if (s1_go && is_clear) begin
      vld_r      <= '0;
      byte_tot_r <= '0;
      pkt_tot_r  <= '0;
    end else if (wr_en) begin
      vld_r[s1_addr_r] <= 1'b1;
      byte_tot_r       <= byte_tot_r + COUNT_WIDTH'(1);
      if (s1_last_r) begin
        pkt_tot_r <= pkt_tot_r + COUNT_WIDTH'(1);
      end
    end
  end

  // read result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && is_read) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && is_read) begin
      out_data_r.bin_count     <= 32'(old_cnt);
      out_data_r.total_bytes   <= 32'(byte_tot_r);
      out_data_r.total_packets <= 32'(pkt_tot_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: design/pbh_bin_ram.sv
// single-port-write, single-port-read bin counter memory with registered read
`default_nettype none

module pbh_bin_ram #(
  parameter int COUNT_WIDTH = pbh_pkg::CountWidthDflt
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [pbh_pkg::BinW-1:0] rd_addr,
  output logic      [COUNT_WIDTH-1:0]   rd_data,
  input  wire logic                     wr_en,
  input  wire logic [pbh_pkg::BinW-1:0] wr_addr,
  input  wire logic [COUNT_WIDTH-1:0]   wr_data
);

  logic [COUNT_WIDTH-1:0] mem [pbh_pkg::NumBins];
  logic [COUNT_WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read-before-write on the same edge, caller forwards
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire
